>>> rtl/core/wfr_pkg.sv
// ----------------------------------------------------------------------------
// wfr_pkg
// shared constants and codes of the wiegand frame receiver
// ----------------------------------------------------------------------------
package wfr_pkg;

  localparam int MAX_BITS    = 256;
  localparam int QUEUE_SLOTS = 8;
  localparam int FRAME_BYTES = (MAX_BITS + 7) / 8;

  localparam int BITS_W    = 9;
  localparam int IDX_W     = 5;
  localparam int SLOT_W    = $clog2(QUEUE_SLOTS);
  localparam int QB_DEPTH  = QUEUE_SLOTS * FRAME_BYTES;
  localparam int QB_ADDR_W = $clog2(QB_DEPTH);
  localparam int MS_W      = 16;

  localparam logic [MS_W-1:0] TIMEOUT_RESET = 16'd100;
  localparam logic [MS_W-1:0] MS_MAX        = 16'hFFFF;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  typedef enum logic [1:0] {
    KIND_QUEUED  = 2'd0,
    KIND_DROPPED = 2'd1,
    KIND_EMPTY   = 2'd2,
    KIND_BYTE    = 2'd3
  } kind_t;

endpackage

>>> rtl/core/wfr_ram.sv
// ----------------------------------------------------------------------------
// wfr_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module wfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/wiegand_frame_receiver.sv
// ----------------------------------------------------------------------------
// wiegand_frame_receiver
// wiegand bit collector with a ring queue of received frames
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) carries one item per transfer: a line
//   sample (action 0) or a read request (action 1). output channel
//   (out_valid/out_ready) carries results from an output register.
//   a line sample is taken at its transfer; when it ends a frame, its single
//   result is valid the cycle after the transfer. samples sustain one per
//   cycle while no read is under way and the output register is free.
//   a read request on an empty queue gives one result the next cycle. else
//   the length memory and the first byte are read, then bytes stream one
//   per cycle from the queue memory read port while the output register
//   is free; the input is held until the last byte is loaded. frames are
//   queued in place: the bytes of a frame are written straight into the
//   head slot. reset clears pointers, counters and edge memory at once, no
//   clearing pass. a stalled receiver holds the output register and blocks
//   new transfers. timeout_ms is written through cfg_wr_en / cfg_wr_data.
// ----------------------------------------------------------------------------
module wiegand_frame_receiver (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [wfr_pkg::MS_W-1:0]  cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      action,
  input  logic                      line_d0,
  input  logic                      line_d1,
  input  logic                      ms_tick,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                kind,
  output logic [7:0]                byte_value,
  output logic [wfr_pkg::IDX_W-1:0] byte_index,
  output logic [wfr_pkg::BITS_W-1:0] bit_total,
  output logic                      last
);

  import wfr_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_STREAM} state_t;

  typedef struct packed {
    logic [BITS_W-1:0] bits;
    logic [7:0]        cur;
    logic              done;
    logic [7:0]        done_byte;
    logic [IDX_W-1:0]  done_idx;
  } app_t;

  function automatic app_t append_bit(app_t s, logic b);
    app_t r;
    r = s;
    if (s.bits < BITS_W'(MAX_BITS)) begin
      r.cur  = {s.cur[6:0], b};
      r.bits = s.bits + 1'b1;
      if (r.bits[2:0] == 3'd0) begin
        r.done      = 1'b1;
        r.done_byte = r.cur;
        r.done_idx  = IDX_W'(s.bits >> 3);
        r.cur       = 8'd0;
      end
    end
    return r;
  endfunction

  function automatic logic [QB_ADDR_W-1:0] qb_addr(logic [SLOT_W-1:0] slot,
                                                   logic [IDX_W-1:0] idx);
    return QB_ADDR_W'(slot) * QB_ADDR_W'(FRAME_BYTES) + QB_ADDR_W'(idx);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_inc(logic [SLOT_W-1:0] p);
    return (p == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  state_t            state;
  logic [MS_W-1:0]   timeout_ms;
  logic [BITS_W-1:0] frame_bits;
  logic [7:0]        cur_byte;
  logic              bits_pending;
  logic [MS_W-1:0]   ms_since_edge;
  logic [1:0]        prev_levels;
  logic [SLOT_W-1:0] head;
  logic [SLOT_W-1:0] tail;
  logic [IDX_W-1:0]  rd_byte;
  logic [IDX_W-1:0]  last_idx;

  logic              in_xfer;
  logic              out_free;
  logic              out_load;
  logic              sample;
  logic              rd_req;
  logic              fall0;
  logic              fall1;
  app_t              a_base;
  app_t              a0;
  app_t              a1;
  logic [MS_W-1:0]   ms_next;
  logic              frame_end;
  logic [SLOT_W-1:0] head_inc;
  logic              q_full;
  logic              q_empty;

  logic                 qb_wr_en;
  logic [QB_ADDR_W-1:0] qb_wr_addr;
  logic [7:0]           qb_wr_data;
  logic                 qb_rd_en;
  logic [QB_ADDR_W-1:0] qb_rd_addr;
  logic [7:0]           qb_rd_data;
  logic                 ql_wr_en;
  logic                 ql_rd_en;
  logic [BITS_W-1:0]    ql_rd_data;
  logic [BITS_W-1:0]    len_m1;

  always_comb begin
    out_free = !out_valid || out_ready;
    in_ready = (state == ST_IDLE) && out_free;
    in_xfer  = in_valid && in_ready;
    sample   = in_xfer && (action == ACT_SAMPLE);
    rd_req   = in_xfer && (action == ACT_READ);

    fall0 = prev_levels[0] && !line_d0;
    fall1 = prev_levels[1] && !line_d1;

    a_base = '{bits: frame_bits, cur: cur_byte, done: 1'b0,
               done_byte: 8'd0, done_idx: '0};
    a0 = fall0 ? append_bit(a_base, 1'b0) : a_base;
    a1 = fall1 ? append_bit(a0, 1'b1) : a0;

    if (fall0 || fall1) begin
      ms_next = '0;
    end else if (ms_tick && ms_since_edge != MS_MAX) begin
      ms_next = ms_since_edge + 1'b1;
    end else begin
      ms_next = ms_since_edge;
    end

    frame_end = sample && (ms_next > timeout_ms) && line_d0 && line_d1 && bits_pending;
    head_inc  = slot_inc(head);
    q_full    = head_inc == tail;
    q_empty   = head == tail;
    out_load  = frame_end || (rd_req && q_empty) || (state == ST_STREAM && out_free);

    // complete bytes go straight into the head slot, the partial one at frame end
    qb_wr_en   = 1'b0;
    qb_wr_addr = qb_addr(head, a1.done_idx);
    qb_wr_data = a1.done_byte;
    if (sample && a1.done) begin
      qb_wr_en = 1'b1;
    end else if (frame_end && !q_full && frame_bits[2:0] != 3'd0) begin
      qb_wr_en   = 1'b1;
      qb_wr_addr = qb_addr(head, IDX_W'(frame_bits >> 3));
      qb_wr_data = cur_byte;
    end
    ql_wr_en = frame_end && !q_full;

    ql_rd_en = rd_req;
    qb_rd_en = rd_req || (state == ST_STREAM && out_free && rd_byte != last_idx);
    qb_rd_addr = (state == ST_IDLE) ? qb_addr(tail, '0) : qb_addr(tail, rd_byte + 1'b1);

    len_m1 = ql_rd_data - 1'b1;
  end

  wfr_ram #(.WIDTH(8), .DEPTH(QB_DEPTH)) u_queue_bytes (
    .clk     (clk),
    .wr_en   (qb_wr_en),
    .wr_addr (qb_wr_addr),
    .wr_data (qb_wr_data),
    .rd_en   (qb_rd_en),
    .rd_addr (qb_rd_addr),
    .rd_data (qb_rd_data)
  );

  wfr_ram #(.WIDTH(BITS_W), .DEPTH(QUEUE_SLOTS)) u_queue_lengths (
    .clk     (clk),
    .wr_en   (ql_wr_en),
    .wr_addr (head),
    .wr_data (frame_bits),
    .rd_en   (ql_rd_en),
    .rd_addr (tail),
    .rd_data (ql_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      timeout_ms    <= TIMEOUT_RESET;
      frame_bits    <= '0;
      cur_byte      <= 8'd0;
      bits_pending  <= 1'b0;
      ms_since_edge <= '0;
      prev_levels   <= 2'b11;
      head          <= '0;
      tail          <= '0;
      rd_byte       <= '0;
      last_idx      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        timeout_ms <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (sample) begin
            prev_levels   <= {line_d1, line_d0};
            ms_since_edge <= ms_next;
            if (frame_end) begin
              frame_bits   <= '0;
              cur_byte     <= 8'd0;
              bits_pending <= 1'b0;
              if (!q_full) begin
                head <= head_inc;
              end
              kind       <= q_full ? KIND_DROPPED : KIND_QUEUED;
              byte_value <= 8'd0;
              byte_index <= '0;
              bit_total  <= frame_bits;
              last       <= 1'b1;
            end else begin
              frame_bits <= a1.bits;
              cur_byte   <= a1.cur;
              if (fall0 || fall1) begin
                bits_pending <= 1'b1;
              end
            end
          end else if (rd_req) begin
            if (q_empty) begin
              kind       <= KIND_EMPTY;
              byte_value <= 8'd0;
              byte_index <= '0;
              bit_total  <= '0;
              last       <= 1'b1;
            end else begin
              state <= ST_FETCH;
            end
          end
        end
        ST_FETCH: begin
          last_idx <= (ql_rd_data == '0) ? '0 : IDX_W'(len_m1 >> 3);
          rd_byte  <= '0;
          state    <= ST_STREAM;
        end
        ST_STREAM: begin
          if (out_free) begin
            kind       <= KIND_BYTE;
            byte_value <= qb_rd_data;
            byte_index <= rd_byte;
            bit_total  <= ql_rd_data;
            last       <= rd_byte == last_idx;
            if (rd_byte == last_idx) begin
              tail  <= slot_inc(tail);
              state <= ST_IDLE;
            end else begin
              rd_byte <= rd_byte + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_no_collide: assert property (@(posedge clk) disable iff (rst)
    qb_wr_en && qb_rd_en |-> qb_wr_addr != qb_rd_addr)
    else $error("queue memory read and write hit the same entry");

  a_bits_bound: assert property (@(posedge clk) disable iff (rst)
    frame_bits <= BITS_W'(MAX_BITS))
    else $error("frame bit count beyond limit");

  a_fetch_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_FETCH |-> head != tail)
    else $error("frame fetch from an empty queue");

  a_empty_reply: assert property (@(posedge clk) disable iff (rst)
    rd_req && q_empty |=> out_valid && kind == KIND_EMPTY && last)
    else $error("read of empty queue gave no empty reply");

endmodule
